// File: design/cabn_pkg.sv
// Shared types and constants for class-aware box suppression.
// No dependencies.
`default_nettype none

package cabn_pkg;

    localparam int GEO_W    = 12;
    localparam int CLS_W    = 8;
    localparam int SCORE_W  = 16;
    localparam int THR_W    = 16;
    localparam int KEPT_W   = 6;
    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic insert;
        logic drain;
    } t_sort_ctl;

    typedef struct packed {
        logic adv;
        logic clear;
    } t_supp_ctl;

endpackage

`default_nettype wire

// File: design/cabn_if.sv
// Channel interfaces: candidate box input, kept result output, threshold write.
// Depends on cabn_pkg.
`default_nettype none

interface cabn_box_if import cabn_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [GEO_W-1:0]   box_left;
    logic [GEO_W-1:0]   box_top;
    logic [GEO_W-1:0]   box_width;
    logic [GEO_W-1:0]   box_height;
    logic [CLS_W-1:0]   class_id;
    logic [SCORE_W-1:0] score;
    logic               last_box;

    modport source (output valid, box_left, box_top, box_width, box_height,
                    class_id, score, last_box, input ready);
    modport sink   (input valid, box_left, box_top, box_width, box_height,
                    class_id, score, last_box, output ready);
endinterface

interface cabn_kept_if import cabn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KEPT_W-1:0] kept_index;
    logic              last_kept;
    logic              overflow;

    modport source (output valid, kept_index, last_kept, overflow, input ready);
    modport sink   (input valid, kept_index, last_kept, overflow, output ready);
endinterface

interface cabn_cfg_if import cabn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] iou_threshold;

    modport source (output valid, iou_threshold, input ready);
    modport sink   (input valid, iou_threshold, output ready);
endinterface

`default_nettype wire

// File: design/class_aware_box_nms.sv
// Class-aware greedy box suppression: top level with control and output stage.
// Depends on cabn_pkg, cabn_if, cabn_sort_cell and cabn_supp_cell.
//
// Boxes are accepted one per cycle and inserted in score order (ties in arrival
// order) into a chain of sort cells. After the last box the input goes not
// ready; unless the output stalls, the sorted set shifts out one box per cycle
// into a chain of suppression cells, where each box walks past the kept boxes
// through each cell's registered overlap stages and claims the first free cell
// when nothing suppresses it. The next set is accepted once that chain empties.
// Boxes past MAX_BOXES are dropped and flagged on every result of the set. The
// user must write the threshold only between sets; the block does not enforce
// this and takes writes in the load state, also while a set is arriving.
`default_nettype none

module class_aware_box_nms import cabn_pkg::*; #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cabn_box_if.sink    i_box,
    cabn_cfg_if.sink    i_cfg,
    cabn_kept_if.source o_kept
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int BOX_W = IDX_W + 4*COORD_BITS + CLS_W + SCORE_W;
    localparam int IDX_LO = BOX_W - IDX_W;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [THR_W-1:0]  r_thr;
    logic              r_pend_valid;
    logic [IDX_W-1:0]  r_pend_idx;
    logic              r_out_valid;
    logic [KEPT_W-1:0] r_out_idx;
    logic              r_out_last;
    logic              r_out_ovf;

    logic              accept, room, adv, feed, flush_go, in_ready;
    logic              busy_any, claim_any;
    logic [IDX_W-1:0]  claim_idx;
    logic [BOX_W-1:0]  new_box;
    t_sort_ctl         sort_ctl;
    t_supp_ctl         supp_ctl;

    logic [MAX_BOXES-1:0] s_take, s_valid;
    logic [BOX_W-1:0]     s_box [MAX_BOXES];
    logic [MAX_BOXES-1:0] p_valid, p_claim, p_busy;
    logic [BOX_W-1:0]     p_box [MAX_BOXES];

    assign i_cfg.ready = (r_state == ST_LOAD);
    assign i_box.ready = in_ready;
    assign accept      = i_box.valid && in_ready;
    assign room        = r_count < CNT_W'(MAX_BOXES);
    assign adv         = !r_out_valid || o_kept.ready;

    assign new_box = {r_count[IDX_W-1:0],
                      COORD_BITS'(i_box.box_left), COORD_BITS'(i_box.box_top),
                      COORD_BITS'(i_box.box_width), COORD_BITS'(i_box.box_height),
                      i_box.class_id, i_box.score};

    assign sort_ctl.insert = accept && room;
    assign sort_ctl.drain  = feed;
    assign supp_ctl.adv    = adv;
    assign supp_ctl.clear  = flush_go;

    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        logic             prev_take, prev_valid, next_valid;
        logic [BOX_W-1:0] prev_box, next_box, supp_in_box;
        logic             supp_in_valid;

        if (k == 0) begin : g_head
            assign prev_take     = 1'b0;
            assign prev_valid    = 1'b0;
            assign prev_box      = '0;
            assign supp_in_valid = feed;
            assign supp_in_box   = s_box[0];
        end else begin : g_body
            assign prev_take     = s_take[k-1];
            assign prev_valid    = s_valid[k-1];
            assign prev_box      = s_box[k-1];
            assign supp_in_valid = p_valid[k-1];
            assign supp_in_box   = p_box[k-1];
        end

        if (k == MAX_BOXES - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_box   = '0;
        end else begin : g_mid
            assign next_valid = s_valid[k+1];
            assign next_box   = s_box[k+1];
        end

        cabn_sort_cell #(.BOX_W(BOX_W)) u_sort (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (sort_ctl),
            .i_new        (new_box),
            .i_prev_take  (prev_take),
            .i_prev_valid (prev_valid),
            .i_prev_box   (prev_box),
            .i_next_valid (next_valid),
            .i_next_box   (next_box),
            .o_valid      (s_valid[k]),
            .o_box        (s_box[k]),
            .o_take       (s_take[k])
        );

        cabn_supp_cell #(.COORD_BITS(COORD_BITS), .IDX_W(IDX_W)) u_supp (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (supp_ctl),
            .i_thr   (r_thr),
            .i_valid (supp_in_valid),
            .i_box   (supp_in_box),
            .o_valid (p_valid[k]),
            .o_box   (p_box[k]),
            .o_claim (p_claim[k]),
            .o_busy  (p_busy[k])
        );
    end

    assign busy_any  = |p_busy;
    assign claim_any = |p_claim;

    function automatic logic [IDX_W-1:0] p_box_in_idx(input int k);
        logic [BOX_W-1:0] b;
        b = (k == 0) ? s_box[0] : p_box[k-1];
        return b[IDX_LO +: IDX_W];
    endfunction

    always_comb begin
        claim_idx = '0;
        for (int k = 0; k < MAX_BOXES; k++) begin
            claim_idx = claim_idx | ({IDX_W{p_claim[k]}} & p_box_in_idx(k));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && i_box.last_box) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (feed && r_count == CNT_W'(1)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (flush_go) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        feed     = 1'b0;
        flush_go = 1'b0;
        unique case (r_state)
            ST_LOAD:  in_ready = 1'b1;
            ST_DRAIN: feed     = adv;
            ST_FLUSH: flush_go = adv && !busy_any;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_thr        <= THR_RESET;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_thr <= i_cfg.iou_threshold;
            end
            if (accept && room) begin
                r_count <= r_count + CNT_W'(1);
            end else if (feed) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (accept && !room) begin
                r_ovf <= 1'b1;
            end else if (flush_go) begin
                r_ovf <= 1'b0;
            end
            if (adv && claim_any) begin
                r_pend_valid <= 1'b1;
            end else if (flush_go) begin
                r_pend_valid <= 1'b0;
            end
            if ((adv && claim_any && r_pend_valid) || flush_go) begin
                r_out_valid <= 1'b1;
            end else if (o_kept.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && claim_any) begin
            r_pend_idx <= claim_idx;
        end
        if ((adv && claim_any && r_pend_valid) || flush_go) begin
            r_out_idx  <= KEPT_W'(r_pend_idx);
            r_out_last <= flush_go;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_kept.valid      = r_out_valid;
    assign o_kept.kept_index = r_out_idx;
    assign o_kept.last_kept  = r_out_last;
    assign o_kept.overflow   = r_out_ovf;

    a_one_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(p_claim))
        else $error("more than one cell claimed a box");

    a_load_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> !r_pend_valid)
        else $error("pending result left over into load");

    a_drain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_count != '0))
        else $error("drain with empty sort chain");

    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> r_pend_valid)
        else $error("flush without a kept box");

endmodule

`default_nettype wire

// File: design/cabn_sort_cell.sv
// One cell of the score-sorted box chain: parallel insert, shift-out drain.
// Depends on cabn_pkg.
`default_nettype none

module cabn_sort_cell import cabn_pkg::*; #(
    parameter int BOX_W = 82
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_sort_ctl        i_ctl,
    input  wire logic [BOX_W-1:0] i_new,
    input  wire logic             i_prev_take,
    input  wire logic             i_prev_valid,
    input  wire logic [BOX_W-1:0] i_prev_box,
    input  wire logic             i_next_valid,
    input  wire logic [BOX_W-1:0] i_next_box,
    output logic                  o_valid,
    output logic [BOX_W-1:0]      o_box,
    output logic                  o_take
);

    logic             r_valid;
    logic [BOX_W-1:0] r_box;
    logic             take;
    logic             first;

    assign take    = !r_valid || (i_new[SCORE_W-1:0] > r_box[SCORE_W-1:0]);
    assign first   = take && !i_prev_take;
    assign o_take  = take;
    assign o_valid = r_valid;
    assign o_box   = r_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.insert && take) begin
            r_valid <= first ? 1'b1 : i_prev_valid;
        end else if (i_ctl.drain) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && take) begin
            r_box <= first ? i_new : i_prev_box;
        end else if (i_ctl.drain) begin
            r_box <= i_next_box;
        end
    end

endmodule

`default_nettype wire

// File: design/cabn_supp_cell.sv
// One cell of the suppression chain: holds a kept box, tests passing boxes.
// Two-stage overlap test; depends on cabn_pkg.
`default_nettype none

module cabn_supp_cell import cabn_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int IDX_W      = 6
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire t_supp_ctl                               i_ctl,
    input  wire logic [THR_W-1:0]                        i_thr,
    input  wire logic                                    i_valid,
    input  wire logic [IDX_W+4*COORD_BITS+CLS_W+SCORE_W-1:0] i_box,
    output logic                                         o_valid,
    output logic [IDX_W+4*COORD_BITS+CLS_W+SCORE_W-1:0]  o_box,
    output logic                                         o_claim,
    output logic                                         o_busy
);

    localparam int C      = COORD_BITS;
    localparam int BOX_W  = IDX_W + 4*C + CLS_W + SCORE_W;
    localparam int CLS_LO = SCORE_W;
    localparam int H_LO   = SCORE_W + CLS_W;
    localparam int W_LO   = H_LO + C;
    localparam int T_LO   = W_LO + C;
    localparam int L_LO   = T_LO + C;
    localparam int INT_W  = 2*C + 2;
    localparam int UNI_W  = 2*C + 1;
    localparam int CMP_W  = INT_W + THR_W;

    logic             r_res_valid;
    logic [BOX_W-1:0] r_res;
    logic             r_s1_valid;
    logic [BOX_W-1:0] r_s1_box;
    logic [INT_W-1:0] r_s1_inter;
    logic [UNI_W-1:0] r_s1_uni;
    logic             r_s1_same;
    logic             r_s2_valid;
    logic [BOX_W-1:0] r_s2_box;

    logic [C-1:0]     ax1, ay1, aw, ah, bx1, by1, bw, bh, ix1, iy1;
    logic [C:0]       ax2, ay2, bx2, by2, ix2, iy2, iw, ih;
    logic [INT_W-1:0] inter;
    logic [2*C-1:0]   area_a, area_b;
    logic [UNI_W-1:0] uni;
    logic [CMP_W-1:0] lhs, rhs;
    logic             supp;

    always_comb begin
        ax1 = r_res[L_LO +: C];
        ay1 = r_res[T_LO +: C];
        aw  = r_res[W_LO +: C];
        ah  = r_res[H_LO +: C];
        bx1 = i_box[L_LO +: C];
        by1 = i_box[T_LO +: C];
        bw  = i_box[W_LO +: C];
        bh  = i_box[H_LO +: C];
        ax2 = {1'b0, ax1} + {1'b0, aw};
        ay2 = {1'b0, ay1} + {1'b0, ah};
        bx2 = {1'b0, bx1} + {1'b0, bw};
        by2 = {1'b0, by1} + {1'b0, bh};
        ix1 = (ax1 > bx1) ? ax1 : bx1;
        iy1 = (ay1 > by1) ? ay1 : by1;
        ix2 = (ax2 < bx2) ? ax2 : bx2;
        iy2 = (ay2 < by2) ? ay2 : by2;
        iw  = (ix2 > {1'b0, ix1}) ? ix2 - {1'b0, ix1} : '0;
        ih  = (iy2 > {1'b0, iy1}) ? iy2 - {1'b0, iy1} : '0;
        inter  = iw * ih;
        area_a = aw * ah;
        area_b = bw * bh;
        uni    = UNI_W'(area_a) + UNI_W'(area_b) - UNI_W'(inter);
    end

    assign lhs  = {r_s1_inter, {THR_W{1'b0}}};
    assign rhs  = CMP_W'(i_thr * r_s1_uni);
    assign supp = r_s1_same && (r_s1_uni != '0) && (lhs > rhs);

    assign o_claim = i_valid && !r_res_valid;
    assign o_valid = r_s2_valid;
    assign o_box   = r_s2_box;
    assign o_busy  = r_s1_valid || r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_res_valid <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else if (i_ctl.adv) begin
            if (o_claim) begin
                r_res_valid <= 1'b1;
            end
            r_s1_valid <= i_valid && r_res_valid;
            r_s2_valid <= r_s1_valid && !supp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            if (o_claim) begin
                r_res <= i_box;
            end
            r_s1_box   <= i_box;
            r_s1_inter <= inter;
            r_s1_uni   <= uni;
            r_s1_same  <= (r_res[CLS_LO +: CLS_W] == i_box[CLS_LO +: CLS_W]);
            r_s2_box   <= r_s1_box;
        end
    end

endmodule

`default_nettype wire

// File: tb/class_aware_box_nms_test.sv
// Testbench for class_aware_box_nms: sends sets of candidate boxes and checks the
// kept indices against a score-ordered greedy suppression predictor.
// Depends on cabn_pkg, cabn_if and the class_aware_box_nms RTL.
`default_nettype none

module class_aware_box_nms_test;
    import cabn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BOXES  = 64;
    localparam int CFG_THR    = 0;
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic [GEO_W-1:0]   left;
        logic [GEO_W-1:0]   top;
        logic [GEO_W-1:0]   width;
        logic [GEO_W-1:0]   height;
        logic [CLS_W-1:0]   cls;
        logic [SCORE_W-1:0] score;
    } t_box;

    typedef struct {
        logic [KEPT_W-1:0] index;
        logic              last;
        logic              ovf;
    } t_kept;

    logic i_clk;
    logic i_rst_n;

    cabn_box_if  box_ch ();
    cabn_kept_if kept_ch ();
    cabn_cfg_if  cfg_ch ();

    class_aware_box_nms #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(GEO_W)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_kept  (kept_ch.source)
    );

    t_box              set_boxes[$];
    t_kept             kept_queue[$];
    logic [THR_W-1:0]  threshold;
    bit                set_overflow;
    int                mismatches;
    int                results_seen;
    int                boxes_sent;
    int                sets_sent;
    int                idle_cycles;
    bit                send_idle_en;
    bit                recv_idle_en;
    bit                hold_recv;
    bit                hold_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit overlap_exceeds(t_box a, t_box b, logic [THR_W-1:0] thr);
        longint unsigned ax2, ay2, bx2, by2, ix1, iy1, ix2, iy2, iw, ih, inter, uni;
        ax2 = a.left + a.width;
        ay2 = a.top + a.height;
        bx2 = b.left + b.width;
        by2 = b.top + b.height;
        ix1 = (a.left > b.left) ? a.left : b.left;
        iy1 = (a.top > b.top) ? a.top : b.top;
        ix2 = (ax2 < bx2) ? ax2 : bx2;
        iy2 = (ay2 < by2) ? ay2 : by2;
        iw = (ix2 > ix1) ? ix2 - ix1 : 0;
        ih = (iy2 > iy1) ? iy2 - iy1 : 0;
        inter = iw * ih;
        uni = longint'(a.width) * a.height + longint'(b.width) * b.height - inter;
        if (uni == 0) return 1'b0;
        return (inter << 16) > longint'(thr) * uni;
    endfunction

    // Sort stored boxes by descending score, keep greedily, queue kept indices.
    task automatic predict_kept_set();
        int order[$];
        bit dead[];
        int n, pos, a, b, last_pos;
        t_kept kk;
        n = set_boxes.size();
        dead = new[n];
        for (int i = 0; i < n; i++) begin
            pos = order.size();
            while (pos > 0 && set_boxes[order[pos-1]].score < set_boxes[i].score) pos--;
            order.insert(pos, i);
        end
        last_pos = -1;
        for (int i = 0; i < n; i++) begin
            a = order[i];
            if (dead[a]) continue;
            kk.index = a[KEPT_W-1:0];
            kk.last  = 1'b0;
            kk.ovf   = set_overflow;
            kept_queue.insert(kept_queue.size(), kk);
            last_pos = kept_queue.size() - 1;
            for (int j = i + 1; j < n; j++) begin
                b = order[j];
                if (dead[b] || set_boxes[a].cls != set_boxes[b].cls) continue;
                if (overlap_exceeds(set_boxes[a], set_boxes[b], threshold)) dead[b] = 1'b1;
            end
        end
        if (last_pos >= 0) kept_queue[last_pos].last = 1'b1;
        set_boxes.delete();
        set_overflow = 1'b0;
    endtask

    task automatic idle_burst(bit enable);
        if (enable && $urandom_range(0, 3) == 0) begin
            box_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_box(t_box bx, bit last);
        idle_burst(send_idle_en);
        box_ch.valid      <= 1'b1;
        box_ch.box_left   <= bx.left;
        box_ch.box_top    <= bx.top;
        box_ch.box_width  <= bx.width;
        box_ch.box_height <= bx.height;
        box_ch.class_id   <= bx.cls;
        box_ch.score      <= bx.score;
        box_ch.last_box   <= last;
        @(posedge i_clk);
        while (!box_ch.ready) @(posedge i_clk);
        boxes_sent++;
        if (set_boxes.size() < MAX_BOXES) set_boxes.insert(set_boxes.size(), bx);
        else set_overflow = 1'b1;
        if (last) begin
            sets_sent++;
            predict_kept_set();
        end
    endtask

    function automatic t_box rand_box(int cls_max, int span);
        t_box bx;
        bx.left   = GEO_W'($urandom_range(0, span));
        bx.top    = GEO_W'($urandom_range(0, span));
        bx.width  = GEO_W'($urandom_range(0, span));
        bx.height = GEO_W'($urandom_range(0, span));
        bx.cls    = CLS_W'($urandom_range(0, cls_max));
        bx.score  = SCORE_W'($urandom);
        return bx;
    endfunction

    // Clustered set: jittered copies of a few seeds so suppression fires often.
    task automatic send_cluster_set(int count);
        t_box seeds[4];
        t_box bx;
        for (int s = 0; s < 4; s++) seeds[s] = rand_box(2, 4095);
        for (int i = 0; i < count; i++) begin
            bx = seeds[$urandom_range(0, 3)];
            bx.left   = GEO_W'(bx.left + $urandom_range(0, 8));
            bx.top    = GEO_W'(bx.top + $urandom_range(0, 8));
            bx.width  = GEO_W'(bx.width + $urandom_range(0, 8));
            bx.height = GEO_W'(bx.height + $urandom_range(0, 8));
            bx.score  = ($urandom_range(0, 3) == 0) ? 16'(100) : 16'($urandom);
            if ($urandom_range(0, 7) == 0) bx = rand_box(255, 4095);
            send_box(bx, i == count - 1);
        end
    endtask

    task automatic wait_drained();
        box_ch.valid <= 1'b0;
        while (kept_queue.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_BOXES + 10) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        wait_drained();
        cfg_ch.valid         <= 1'b1;
        cfg_ch.iou_threshold <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        threshold = value;
    endtask

    task automatic test_directed();
        t_box bx;
        // identical boxes, tied scores: first arrival wins
        bx = '{left: 10, top: 10, width: 20, height: 20, cls: 1, score: 500};
        send_box(bx, 1'b0);
        send_box(bx, 1'b0);
        bx.cls = 2;
        send_box(bx, 1'b1);
        // zero-area boxes never suppress each other
        bx = '{left: 5, top: 5, width: 0, height: 0, cls: 0, score: 0};
        send_box(bx, 1'b0);
        send_box(bx, 1'b1);
        // field extremes, single-box set
        bx = '{left: 4095, top: 4095, width: 4095, height: 4095, cls: 255, score: 16'hFFFF};
        send_box(bx, 1'b1);
        bx = '{left: 0, top: 0, width: 4095, height: 4095, cls: 255, score: 16'hFFFF};
        send_box(bx, 1'b0);
        bx.left = 2048;
        bx.score = 1;
        send_box(bx, 1'b0);
        bx = '{left: 100, top: 0, width: 4000, height: 4095, cls: 255, score: 16'h8000};
        send_box(bx, 1'b1);
    endtask

    task automatic test_overflow();
        t_box bx;
        for (int i = 0; i < MAX_BOXES + 3; i++) begin
            bx = rand_box(3, 200);
            send_box(bx, i == MAX_BOXES + 2);
        end
    endtask

    task automatic test_thresholds();
        write_threshold(16'd0);
        send_cluster_set(6);
        write_threshold(16'hFFFF);
        send_cluster_set(6);
        write_threshold(16'd16384);
        send_cluster_set(6);
        write_threshold(THR_RESET);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_recv = 1'b1;
        send_cluster_set(10);
        send_cluster_set(10);
        hold_recv = 1'b0;
        wait_drained();
    endtask

    task automatic test_random(int total);
        int sent_here;
        sent_here = 0;
        while (sent_here < total) begin
            if (sent_here > total * 3 / 4) begin
                send_idle_en = 1'b0;
                recv_idle_en = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) write_threshold(16'($urandom));
            begin
                int count;
                count = $urandom_range(1, 12);
                if ($urandom_range(0, 4) == 0) begin
                    for (int i = 0; i < count; i++)
                        send_box(rand_box(255, 4095), i == count - 1);
                end else begin
                    send_cluster_set(count);
                end
                sent_here += count;
            end
        end
    endtask

    // Receiver: random stalls plus one long counted hold-off on request.
    initial begin
        kept_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_recv && !hold_done) begin
                kept_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
                kept_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                kept_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_kept exp_k;
        if (i_rst_n && kept_ch.valid && kept_ch.ready) begin
            results_seen++;
            if (kept_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result index=%0d", kept_ch.kept_index);
            end else begin
                exp_k = kept_queue.pop_front();
                if (kept_ch.kept_index !== exp_k.index || kept_ch.last_kept !== exp_k.last
                        || kept_ch.overflow !== exp_k.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx=%0d last=%0b ovf=%0b got idx=%0d last=%0b ovf=%0b",
                                 exp_k.index, exp_k.last, exp_k.ovf, kept_ch.kept_index,
                                 kept_ch.last_kept, kept_ch.overflow);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((box_ch.valid && box_ch.ready) || (kept_ch.valid && kept_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        threshold     = THR_RESET;
        set_overflow  = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        boxes_sent    = 0;
        sets_sent     = 0;
        hold_recv     = 1'b0;
        send_idle_en  = 1'b1;
        recv_idle_en  = 1'b1;
        box_ch.valid  <= 1'b0;
        box_ch.box_left <= '0;
        box_ch.box_top <= '0;
        box_ch.box_width <= '0;
        box_ch.box_height <= '0;
        box_ch.class_id <= '0;
        box_ch.score <= '0;
        box_ch.last_box <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.iou_threshold <= '0;
        i_rst_n       <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_thresholds();
        test_backpressure();
        test_overflow();
        test_random(160);

        wait_drained();
        $display("Sent %0d boxes in %0d sets, checked %0d kept results,", boxes_sent,
                 sets_sent, results_seen);
        $display("covering ties, zero areas, overflow, threshold extremes and stalls.");
        if (mismatches == 0 && kept_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
